// ----- hdl/ewma_variance_zscore_tracker_unit_macros.svh -----
// assertion macros for the tracker checker
`ifndef EWMA_VARIANCE_ZSCORE_TRACKER_UNIT_MACROS_SVH
`define EWMA_VARIANCE_ZSCORE_TRACKER_UNIT_MACROS_SVH
// implication checked every clock outside reset
`define EVZ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication checked outside reset
`define EVZ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ----- hdl/evz_pkg.sv -----
// package: types and constants of the tracker
`default_nettype none
package evz_pkg;
  localparam int CHANNELS_DEF = 64;
  localparam int ALPHA_W = 17;
  localparam int Z_W = 16;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd8192;
  localparam logic [Z_W-1:0] Z_RST = 16'd768;
  localparam logic [ALPHA_W-1:0] ONE_Q16 = 17'd65536;
  localparam logic [47:0] VAR_MAX = 48'hFFFF_FFFF_FFFF;
  localparam logic CFG_ALPHA = 1'b0;
  localparam logic CFG_Z = 1'b1;

  typedef struct packed {
    logic [5:0] channel;
    logic signed [31:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] mean;
    logic [47:0] variance;
    logic anomaly;
    logic first_sample;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_READ, S_WAIT, S_P1, S_P2, S_P3, S_P4, S_P5, S_P6, S_P7, S_P8, S_P9, S_P10,
    S_OUT
  } state_t;
endpackage
`default_nettype wire

// ----- hdl/evz_ram.sv -----
// generic single-port ram with registered read
`default_nettype none
module evz_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(DEPTH)-1:0] addr,
  input wire logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- hdl/evz_front.sv -----
// front: input queue of two items, drops out-of-range channels
`default_nettype none
module evz_front #(
  parameter int CHANNELS = evz_pkg::CHANNELS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire evz_pkg::in_item_t din,
  output logic full,
  input wire logic take,
  output logic avail,
  output evz_pkg::in_item_t dout
);
  import evz_pkg::*;
  in_item_t q [2];
  logic [1:0] cnt;
  logic rd, wr, keep;
  assign keep = ({26'd0, din.channel} < 32'(CHANNELS));
  assign full = (cnt == 2'd2);
  assign avail = (cnt != 2'd0);
  assign dout = q[rd];
  logic acc, deq;
  assign acc = push && !full && keep;
  assign deq = take && avail;
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0; rd <= 1'b0; wr <= 1'b0;
    end else begin
      if (acc) wr <= ~wr;
      if (deq) rd <= ~rd;
      cnt <= cnt + {1'b0, acc} - {1'b0, deq};
    end
  end
  always_ff @(posedge clk) begin
    if (acc) q[wr] <= din;
  end
endmodule
`default_nettype wire

// ----- hdl/evz_back.sv -----
// back: per-channel read-modify-write with a shared multiplier
`default_nettype none
module evz_back #(
  parameter int CHANNELS = evz_pkg::CHANNELS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic avail,
  input wire evz_pkg::in_item_t item,
  output logic take,
  input wire logic [evz_pkg::ALPHA_W-1:0] alpha,
  input wire logic [evz_pkg::Z_W-1:0] z_limit,
  output logic empty,
  input wire logic pop,
  output evz_pkg::out_item_t dout
);
  import evz_pkg::*;
  localparam int AW = $clog2(CHANNELS);

  state_t state, state_next;
  logic [CHANNELS-1:0] vld;
  in_item_t cur;
  logic [AW-1:0] addr;
  logic [16:0] a;
  logic signed [31:0] m_rd, nm;
  logic [47:0] v_rd, s, nv, t, d2;
  logic [32:0] mag, dev;
  logic [31:0] zz;
  logic [63:0] dev2, plo;
  out_item_t res;
  logic res_full;
  logic we, first;
  logic [33:0] ma;
  logic [33:0] mb;
  logic [67:0] prod;
  logic signed [33:0] delta;
  logic [48:0] ssum;
  logic [50:0] rnd;
  logic [33:0] step;
  logic [49:0] upper;

  assign addr = AW'(cur.channel);
  assign delta = 34'(signed'(cur.sample)) - 34'(signed'(m_rd));
  assign prod = ma * mb;

  evz_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_mean (
    .clk(clk), .we(we), .addr(addr), .wdata(nm), .rdata(m_rd));
  evz_ram #(.WIDTH(48), .DEPTH(CHANNELS)) u_var (
    .clk(clk), .we(we), .addr(addr), .wdata(nv), .rdata(v_rd));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (avail && !res_full) state_next = S_READ;
      S_READ: state_next = first ? S_OUT : S_WAIT;
      S_WAIT: state_next = S_P1;
      S_P1: state_next = S_P2;
      S_P2: state_next = S_P3;
      S_P3: state_next = S_P4;
      S_P4: state_next = S_P5;
      S_P5: state_next = S_P6;
      S_P6: state_next = S_P7;
      S_P7: state_next = S_P8;
      S_P8: state_next = S_P9;
      S_P9: state_next = S_P10;
      S_P10: state_next = S_OUT;
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs and multiplier operand select
  always_comb begin
    take = (state == S_IDLE) && avail && !res_full;
    we = (state == S_OUT);
    ma = '0;
    mb = '0;
    case (state)
      S_P1: begin ma = {1'b0, mag}; mb = {1'b0, mag}; end
      S_P2: begin ma = {17'd0, a}; mb = {2'b0, d2[47:16]}; end
      S_P3: begin ma = {17'd0, a}; mb = {18'd0, d2[15:0]}; end
      S_P4: begin ma = {17'd0, a}; mb = {1'b0, mag}; end
      S_P5: begin ma = {2'b0, s[47:16]}; mb = 34'(ONE_Q16 - a); end
      S_P6: begin ma = {18'd0, s[15:0]}; mb = 34'(ONE_Q16 - a); end
      S_P7: begin ma = {1'b0, dev}; mb = {1'b0, dev}; end
      S_P8: begin ma = {18'd0, z_limit}; mb = {18'd0, z_limit}; end
      S_P9: begin ma = {2'b0, zz}; mb = {2'b0, nv[31:0]}; end
      S_P10: begin ma = {2'b0, zz}; mb = {18'd0, nv[47:32]}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign first = !vld[addr];
  assign empty = !res_full;
  assign dout = res;

  // saturating sum, rounded mean step and the high word of z^2 * variance
  assign ssum = {1'b0, v_rd} + {1'b0, t};
  assign rnd = delta[33] ? (prod[50:0] + 51'd32767) : (prod[50:0] + 51'd32768);
  assign step = 34'(rnd >> 16);
  assign upper = prod[49:0] + {18'd0, plo[63:32]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      vld <= '0;
      res_full <= 1'b0;
    end else begin
      state <= state_next;
      if (we) vld[addr] <= 1'b1;
      if (we) res_full <= 1'b1;
      else if (pop && res_full) res_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (take) begin
        cur <= item;
        a <= (alpha == 17'd0) ? 17'd1 : ((alpha > ONE_Q16) ? ONE_Q16 : alpha);
      end
      S_READ: if (first) begin
        nm <= cur.sample; nv <= '0; res.anomaly <= 1'b0; res.first_sample <= 1'b1;
      end
      S_WAIT: begin
        mag <= delta[33] ? 33'(-delta) : 33'(delta);
        res.first_sample <= 1'b0;
      end
      S_P1: d2 <= prod[63:16];
      S_P2: t <= prod[47:0];
      S_P3: t <= t + 48'(prod[32:16]);
      S_P4: begin
        nm <= 32'(34'(m_rd) + (delta[33] ? -step : step));
        s <= ssum[48] ? VAR_MAX : ssum[47:0];
      end
      S_P5: nv <= prod[47:0];
      S_P6: begin
        nv <= nv + 48'(prod[31:16]);
        dev <= (34'(signed'(cur.sample)) >= 34'(signed'(nm)))
          ? 33'(34'(signed'(cur.sample)) - 34'(signed'(nm)))
          : 33'(34'(signed'(nm)) - 34'(signed'(cur.sample)));
      end
      S_P7: dev2 <= prod[63:0];
      S_P8: zz <= prod[31:0];
      S_P9: plo <= prod[63:0];
      S_P10: begin
        res.anomaly <= (nv != 48'd0) && (z_limit != 16'd0) && (upper[49:32] == 18'd0)
                       && (dev2 > {upper[31:0], plo[31:0]});
      end
      S_OUT: begin
        res.mean <= nm;
        res.variance <= nv;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- hdl/ewma_variance_zscore_tracker_unit.sv -----
// top level of the moving mean, variance and z-score tracker
`default_nettype none
// per-channel moving mean and variance with an anomaly flag. items enter a two-entry
// input queue (front), out-of-range channels are dropped there; the back reads the
// channel's stored mean and variance, runs the update through one shared multiplier
// and writes back. after the back takes an item, a first sample goes from the store read
// straight to the result, while a later sample also passes through the ten shared
// multiplier steps. one result register holds the outgoing item; the back takes
// no new item until it is popped, while the front keeps taking items until it holds two.
// no clearing pass: channel valid bits reset.
module ewma_variance_zscore_tracker_unit #(
  parameter int CHANNELS = evz_pkg::CHANNELS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  output logic full,
  input wire evz_pkg::in_item_t in_item,
  output logic empty,
  input wire logic pop,
  output evz_pkg::out_item_t out_item,
  input wire logic cfg_valid,
  output logic cfg_ready,
  input wire logic cfg_index,
  input wire logic [31:0] cfg_data
);
  import evz_pkg::*;
  logic [ALPHA_W-1:0] alpha;
  logic [Z_W-1:0] z_limit;
  logic avail, take;
  in_item_t q_item;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ALPHA_RST;
      z_limit <= Z_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ALPHA: alpha <= cfg_data[ALPHA_W-1:0];
        CFG_Z: z_limit <= cfg_data[Z_W-1:0];
        default: ;
      endcase
    end
  end

  evz_front #(.CHANNELS(CHANNELS)) u_front (
    .clk(clk), .rst(rst), .push(push), .din(in_item), .full(full),
    .take(take), .avail(avail), .dout(q_item));

  evz_back #(.CHANNELS(CHANNELS)) u_back (
    .clk(clk), .rst(rst), .avail(avail), .item(q_item), .take(take),
    .alpha(alpha), .z_limit(z_limit), .empty(empty), .pop(pop), .dout(out_item));
endmodule
`default_nettype wire

// ----- hdl/evz_checker.sv -----
// port checker for the tracker, bound to the top level
`default_nettype none
`include "ewma_variance_zscore_tracker_unit_macros.svh"
module evz_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic push,
  input wire logic full,
  input wire logic empty,
  input wire logic pop,
  input wire evz_pkg::out_item_t out_item
);
  `EVZ_ASSERT_NXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(out_item))
  `EVZ_ASSERT_IMP(a_first, clk, rst, !empty && out_item.first_sample, out_item.variance == 48'd0)
  `EVZ_ASSERT_IMP(a_zero, clk, rst, !empty && out_item.variance == 48'd0, !out_item.anomaly)
  `EVZ_ASSERT_NXT(a_pop, clk, rst, pop && !empty, empty)
  `EVZ_ASSERT_NXT(a_no_fill, clk, rst, !full && !push, !full)
endmodule
bind ewma_variance_zscore_tracker_unit evz_checker u_chk (
  .clk(clk), .rst(rst), .push(push), .full(full), .empty(empty), .pop(pop),
  .out_item(out_item));
`default_nettype wire
